/* design/eth_ipv4_tcp_header_check_assert.svh */
// ----------------------------------------------------------------------------
// eth_ipv4_tcp_header_check assertion macros
// Concurrent assertion helpers clocked on clk, disabled in rst.
// ----------------------------------------------------------------------------
`ifndef ETH_IPV4_TCP_HEADER_CHECK_ASSERT_SVH
`define ETH_IPV4_TCP_HEADER_CHECK_ASSERT_SVH

`ifndef SYNTH

// Antecedent holds, consequent holds in the same cycle.
`define EHC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent holds, consequent holds in the next cycle.
`define EHC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define EHC_ASSERT_IMPL(lbl, ante, cons, msg)
`define EHC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* design/eth_hc_pkg.sv */
// ----------------------------------------------------------------------------
// eth_hc_pkg
// Types, codes and constants shared by the header checker modules.
// ----------------------------------------------------------------------------
`default_nettype none

package eth_hc_pkg;

  localparam int unsigned CountW = 17;
  localparam logic [CountW-1:0] COUNT_MAX = '1;

  // Frame byte positions of the captured header fields
  localparam logic [CountW-1:0] POS_ETYPE_HI = 17'd12;
  localparam logic [CountW-1:0] POS_ETYPE_LO = 17'd13;
  localparam logic [CountW-1:0] POS_VER_IHL  = 17'd14;
  localparam logic [CountW-1:0] POS_TOTLEN_HI = 17'd16;
  localparam logic [CountW-1:0] POS_TOTLEN_LO = 17'd17;
  localparam logic [CountW-1:0] POS_FRAG_HI  = 17'd20;
  localparam logic [CountW-1:0] POS_FRAG_LO  = 17'd21;
  localparam logic [CountW-1:0] POS_PROTO    = 17'd23;
  // TCP data offset sits at 14 + IHL*4 + 12
  localparam logic [CountW-1:0] POS_TCP_BASE = 17'd26;

  localparam logic [15:0] ETH_HDR_LEN  = 16'd14;
  localparam logic [15:0] IP_MIN_HDR   = 16'd20;
  localparam logic [15:0] TCP_MIN_HDR  = 16'd20;
  localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
  localparam logic [3:0]  IP_VERSION4  = 4'd4;
  localparam logic [7:0]  PROTO_TCP    = 8'd6;
  localparam logic [15:0] FRAG_MASK    = 16'h3FFF;

  typedef enum logic [3:0] {
    RC_NONE      = 4'd0,
    RC_SHORT     = 4'd1,
    RC_ETHERTYPE = 4'd2,
    RC_VERSION   = 4'd3,
    RC_PROTOCOL  = 4'd4,
    RC_IPHLEN    = 4'd5,
    RC_TOTLEN    = 4'd6,
    RC_TRUNC     = 4'd7,
    RC_FRAGMENT  = 4'd8,
    RC_TCPHLEN   = 4'd9,
    RC_TCPOVER   = 4'd10
  } reject_code_t;

  // Captured header fields of the frame in flight
  typedef struct packed {
    logic [CountW-1:0] byte_count;
    logic [15:0]       ether_type_word;
    logic [7:0]        version_ihl_byte;
    logic [15:0]       ip_total_length;
    logic [15:0]       flags_fragment_word;
    logic [7:0]        ip_protocol;
    logic [3:0]        tcp_offset_nibble;
  } hdr_fields_t;

  typedef struct packed {
    logic [15:0]  payload_length;
    logic [7:0]   payload_offset;
    logic [5:0]   tcp_header_bytes;
    logic [5:0]   ip_header_bytes;
    reject_code_t reject_code;
    logic         accepted;
  } verdict_t;

  localparam int unsigned VerdictW = $bits(verdict_t);
  localparam int unsigned OutDataW = ((VerdictW + 7) / 8) * 8;

endpackage

`default_nettype wire

/* design/eth_hc_judge.sv */
// ----------------------------------------------------------------------------
// eth_hc_judge
// Priority header checks and length math on a snapshot of the captured fields.
// ----------------------------------------------------------------------------
`default_nettype none

module eth_hc_judge
  import eth_hc_pkg::*;
(
  input  hdr_fields_t hdr,
  output verdict_t    verdict
);

  logic [5:0]  ihl_bytes;
  logic [5:0]  tcp_bytes;
  logic [15:0] ihl16;
  logic [15:0] tcp16;
  reject_code_t code;

  assign ihl_bytes = {hdr.version_ihl_byte[3:0], 2'b00};
  assign tcp_bytes = {hdr.tcp_offset_nibble, 2'b00};
  assign ihl16     = {10'd0, ihl_bytes};
  assign tcp16     = {10'd0, tcp_bytes};

  // first failing check wins
  always_comb begin
    if (hdr.byte_count < 17'(ETH_HDR_LEN + IP_MIN_HDR)) begin
      code = RC_SHORT;
    end else if (hdr.ether_type_word != ETYPE_IPV4) begin
      code = RC_ETHERTYPE;
    end else if (hdr.version_ihl_byte[7:4] != IP_VERSION4) begin
      code = RC_VERSION;
    end else if (hdr.ip_protocol != PROTO_TCP) begin
      code = RC_PROTOCOL;
    end else if (ihl16 < IP_MIN_HDR) begin
      code = RC_IPHLEN;
    end else if (hdr.ip_total_length < ihl16 + TCP_MIN_HDR) begin
      code = RC_TOTLEN;
    end else if (hdr.byte_count < {1'b0, ETH_HDR_LEN} + {1'b0, hdr.ip_total_length}) begin
      code = RC_TRUNC;
    end else if ((hdr.flags_fragment_word & FRAG_MASK) != 16'd0) begin
      code = RC_FRAGMENT;
    end else if (tcp16 < TCP_MIN_HDR) begin
      code = RC_TCPHLEN;
    end else if (hdr.ip_total_length < ihl16 + tcp16) begin
      code = RC_TCPOVER;
    end else begin
      code = RC_NONE;
    end
  end

  always_comb begin
    verdict = '0;
    verdict.reject_code = code;
    if (code == RC_NONE) begin
      verdict.accepted         = 1'b1;
      verdict.ip_header_bytes  = ihl_bytes;
      verdict.tcp_header_bytes = tcp_bytes;
      verdict.payload_offset   = ETH_HDR_LEN[7:0] + {2'b00, ihl_bytes} + {2'b00, tcp_bytes};
      verdict.payload_length   = hdr.ip_total_length - ihl16 - tcp16;
    end
  end

endmodule

`default_nettype wire

/* design/eth_ipv4_tcp_header_check.sv */
// ----------------------------------------------------------------------------
// eth_ipv4_tcp_header_check
// Byte-stream Ethernet/IPv4/TCP header checker with one verdict per frame.
// ----------------------------------------------------------------------------
//
//  channel  dir  beat                         tdata                      tlast
//  s_axis   in   one frame byte               [7:0] data_byte            last_byte
//  m_axis   out  one verdict per frame        [40:0] verdict, see below  -
//
//  Cycles: one beat per clock unless a last byte waits on a held verdict; a
//    byte passes the input register, then the field capture and the checks
//    run in one pass into the verdict register.
//  Reset: rst (sync, active high) clears the pipe, byte count and fields.
//  Stalls: m_axis_tready low holds the verdict; only a last byte waits behind
//    it, other bytes keep flowing. State clears after each verdict.
//
`default_nettype none

`include "eth_ipv4_tcp_header_check_assert.svh"

module eth_ipv4_tcp_header_check
  import eth_hc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,

  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] data_byte
  input  logic                s_axis_tlast,   // last_byte

  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [0] accepted, [4:1] reject_code, [10:5] ip_header_bytes,
  // [16:11] tcp_header_bytes, [24:17] payload_offset, [40:25] payload_length,
  // [47:41] zero
  output logic [OutDataW-1:0] m_axis_tdata
);

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       s1_fire;
  logic       out_free;

  // frame state and next value after the byte in s1
  hdr_fields_t fields;
  hdr_fields_t fields_next;
  logic [5:0]  ihl_bytes_next;

  verdict_t    verdict_calc;
  logic        out_valid;
  verdict_t    out_verdict;

  assign out_free      = !out_valid || m_axis_tready;
  // only a last byte needs room in the verdict register
  assign s1_fire       = s1_valid && (!s1_last || out_free);
  assign s_axis_tready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_byte <= s_axis_tdata;
      s1_last <= s_axis_tlast;
    end
  end

  // field capture at fixed byte positions and at the IHL-dependent TCP offset
  always_comb begin
    fields_next = fields;
    case (fields.byte_count)
      POS_ETYPE_HI:  fields_next.ether_type_word[15:8]     = s1_byte;
      POS_ETYPE_LO:  fields_next.ether_type_word[7:0]      = s1_byte;
      POS_VER_IHL:   fields_next.version_ihl_byte          = s1_byte;
      POS_TOTLEN_HI: fields_next.ip_total_length[15:8]     = s1_byte;
      POS_TOTLEN_LO: fields_next.ip_total_length[7:0]      = s1_byte;
      POS_FRAG_HI:   fields_next.flags_fragment_word[15:8] = s1_byte;
      POS_FRAG_LO:   fields_next.flags_fragment_word[7:0]  = s1_byte;
      POS_PROTO:     fields_next.ip_protocol               = s1_byte;
      default: ;
    endcase
    ihl_bytes_next = {fields_next.version_ihl_byte[3:0], 2'b00};
    // TCP data offset nibble, position follows the IHL
    if (fields.byte_count >= POS_TCP_BASE &&
        fields.byte_count == POS_TCP_BASE + {11'd0, ihl_bytes_next}) begin
      fields_next.tcp_offset_nibble = s1_byte[7:4];
    end
    // saturating count
    if (fields.byte_count != COUNT_MAX) begin
      fields_next.byte_count = fields.byte_count + 17'd1;
    end
  end

  eth_hc_judge u_judge (
    .hdr     (fields_next),
    .verdict (verdict_calc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fields <= '0;
    end else if (s1_fire) begin
      fields <= s1_last ? '0 : fields_next;
    end
  end

  // verdict register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last) begin
      out_verdict <= verdict_calc;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OutDataW - VerdictW){1'b0}}, out_verdict};

  // ---- assertions ----
  `EHC_ASSERT_NEXT(a_clear_after_last, s1_fire && s1_last, fields == '0,
    "frame state not cleared after verdict")
  `EHC_ASSERT_NEXT(a_verdict_follows_last, s1_fire && s1_last, out_valid,
    "no verdict after last byte")
  `EHC_ASSERT_IMPL(a_accept_code, out_valid && out_verdict.accepted,
    out_verdict.reject_code == RC_NONE && out_verdict.ip_header_bytes >= 6'd20 &&
    out_verdict.tcp_header_bytes >= 6'd20,
    "accepted verdict with bad code or header length")
  `EHC_ASSERT_IMPL(a_reject_zero, out_valid && !out_verdict.accepted,
    out_verdict.reject_code != RC_NONE && out_verdict.payload_length == 16'd0 &&
    out_verdict.payload_offset == 8'd0,
    "rejected verdict carries nonzero fields")
  `EHC_ASSERT_IMPL(a_last_waits, s1_valid && s1_last && out_valid && !m_axis_tready,
    !s_axis_tready, "last byte passed a held verdict")

endmodule

`default_nettype wire
